[sv/bcdf_pkg.sv]
// Shared types, character codes and helpers for the BCD number formatter.
package bcdf_pkg;

   localparam int NUM_DIGITS = 15;
   localparam int POS_W      = 5;
   localparam int MAG_W      = 11;

   // format codes carried in the high nibble of byte 0
   localparam logic [3:0] KIND_ERROR   = 4'hF;
   localparam logic [3:0] KIND_FRAC    = 4'h2;
   localparam logic [3:0] KIND_RADICAL = 4'h8;

   // exponent word at or above this marks a negative number
   localparam logic [15:0] NEG_BIAS   = 16'h0500;
   localparam logic [MAG_W-1:0] EXP_ZERO = 11'd100;

   // string positions with special meaning
   localparam logic [POS_W-1:0] POS_LAST_ERROR = 5'd4;
   localparam logic [POS_W-1:0] POS_LAST_SHORT = 5'd17;
   localparam logic [POS_W-1:0] POS_LAST_FULL  = 5'd21;

   // ASCII codes
   localparam logic [7:0] CH_PLUS  = 8'h2B;
   localparam logic [7:0] CH_MINUS = 8'h2D;
   localparam logic [7:0] CH_DOT   = 8'h2E;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_UB    = 8'h42;
   localparam logic [7:0] CH_UE    = 8'h45;
   localparam logic [7:0] CH_UO    = 8'h4F;
   localparam logic [7:0] CH_UR    = 8'h52;
   localparam logic [7:0] CH_UT    = 8'h54;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_LA    = 8'h61;
   localparam logic [7:0] CH_LR    = 8'h72;
   localparam logic [7:0] CH_LS    = 8'h73;

   typedef enum logic [2:0] {
      FMT_FLOAT,
      FMT_ZERO,
      FMT_ERROR,
      FMT_FRAC,
      FMT_RADICAL
   } fmt_type;

   // one decoded number, held while its characters go out
   typedef struct packed {
      fmt_type                        fmt;
      logic                           neg;
      logic                           sign2_neg;
      logic                           exp_pos;
      logic [MAG_W-1:0]               mag;
      logic [NUM_DIGITS-1:0][3:0]     digits;
   } item_type;

   // nibble to character: ten prints as a lowercase a
   function automatic logic [7:0] nib_char(input logic [3:0] n);
      logic [7:0] c;
      if (n == 4'd10) c = CH_LA;
      else            c = CH_ZERO + {4'd0, n};
      return c;
   endfunction

endpackage

[sv/bcdf_decode.sv]
// Decodes one raw BCD number into format, sign, exponent magnitude and digits.
module bcdf_decode (
   input  logic [63:0]        mantissa_bytes,
   input  logic [15:0]        exponent_bytes,
   output bcdf_pkg::item_type item
);
   import bcdf_pkg::*;

   logic [15:0]      e_adj;
   logic             neg;
   logic [MAG_W-1:0] val;
   logic             exp_pos;

   // sign strip and exponent value from the three nibbles
   assign neg     = exponent_bytes >= NEG_BIAS;
   assign e_adj   = neg ? (exponent_bytes - NEG_BIAS) : exponent_bytes;
   assign val     = MAG_W'(e_adj[11:8]) * MAG_W'(100)
                  + MAG_W'(e_adj[7:4]) * MAG_W'(10)
                  + MAG_W'(e_adj[3:0]);
   assign exp_pos = val >= EXP_ZERO;

   always_comb begin
      item.neg       = neg;
      item.exp_pos   = exp_pos;
      item.mag       = exp_pos ? (val - EXP_ZERO) : (EXP_ZERO - val);
      item.sign2_neg = exponent_bytes[7:0] >= 8'd5;

      // digit order: byte 0 low, then bytes 1..7 high then low
      item.digits[0] = mantissa_bytes[3:0];
      for (int k = 0; k < 7; k++) begin
         item.digits[1 + 2*k] = mantissa_bytes[8*(k+1) + 4 +: 4];
         item.digits[2 + 2*k] = mantissa_bytes[8*(k+1) +: 4];
      end

      // format select; error wins over a zero exponent
      if (mantissa_bytes[7:4] == KIND_ERROR) begin
         item.fmt = FMT_ERROR;
      end else if (exponent_bytes == 16'd0) begin
         item.fmt = FMT_ZERO;
      end else begin
         unique case (mantissa_bytes[7:4])
            KIND_FRAC:    item.fmt = FMT_FRAC;
            KIND_RADICAL: item.fmt = FMT_RADICAL;
            default:      item.fmt = FMT_FLOAT;
         endcase
      end
   end

endmodule

[sv/bcdf_char_sel.sv]
// Selects the character at one string position of a decoded number.
module bcdf_char_sel (
   input  bcdf_pkg::item_type item,
   input  logic [4:0]         pos,
   output logic [7:0]         character,
   output logic               is_last
);
   import bcdf_pkg::*;

   logic [23:0] q_prod;
   logic [3:0]  hund;
   logic [6:0]  r100;
   logic [14:0] t_prod;
   logic [3:0]  tens;
   logic [3:0]  ones;
   logic [7:0]  v;
   logic [7:0]  sign_ch;
   logic [7:0]  lit_ch;
   logic        use_digit;
   logic [3:0]  digit_idx;

   // exponent magnitude split by reciprocal multiplies (exact below 1029 / 43699)
   assign q_prod = 24'(item.mag) * 24'd5243;
   assign hund   = q_prod[22:19];
   assign r100   = 7'(item.mag - MAG_W'(hund) * MAG_W'(100));
   assign t_prod = 15'(r100) * 15'd205;
   assign tens   = t_prod[14:11];
   assign ones   = 4'(r100 - 7'(tens) * 7'd10);
   assign v      = {tens, 4'd0} + 8'(ones) + 8'(hund);

   assign sign_ch = item.neg ? CH_MINUS : CH_PLUS;

   // per-format layout
   always_comb begin
      lit_ch    = CH_ZERO;
      use_digit = 1'b0;
      digit_idx = 4'd0;
      is_last   = pos == POS_LAST_FULL;
      unique case (item.fmt)
         FMT_ERROR: begin
            is_last = pos == POS_LAST_ERROR;
            case (pos)
               5'd0:    lit_ch = CH_UE;
               5'd1:    lit_ch = CH_UR;
               5'd2:    lit_ch = CH_UR;
               5'd3:    lit_ch = CH_UO;
               5'd4:    lit_ch = CH_UR;
               default: lit_ch = CH_ZERO;
            endcase
         end
         FMT_ZERO: begin
            case (pos)
               5'd0:    lit_ch = CH_PLUS;
               5'd2:    lit_ch = CH_DOT;
               5'd17:   lit_ch = CH_UE;
               5'd18:   lit_ch = CH_PLUS;
               default: lit_ch = CH_ZERO;
            endcase
         end
         FMT_FRAC: begin
            is_last = pos == ((item.mag > MAG_W'(17)) ? POS_LAST_SHORT : POS_LAST_FULL);
            if (pos == 5'd0) begin
               lit_ch = sign_ch;
            end else if (pos == 5'd17) begin
               lit_ch = CH_UB;
            end else if (MAG_W'(pos) > item.mag) begin
               lit_ch = CH_SPACE;
            end else if (pos <= 5'd15) begin
               use_digit = 1'b1;
               digit_idx = 4'(pos - 5'd1);
            end else if (pos == 5'd16) begin
               lit_ch = CH_UE;
            end else begin
               lit_ch = CH_ZERO;
            end
         end
         FMT_RADICAL: begin
            case (pos)
               5'd0:    lit_ch = sign_ch;
               5'd1:    begin use_digit = 1'b1; digit_idx = 4'd3;  end
               5'd2:    begin use_digit = 1'b1; digit_idx = 4'd4;  end
               5'd3:    lit_ch = CH_LR;
               5'd4:    begin use_digit = 1'b1; digit_idx = 4'd0;  end
               5'd5:    begin use_digit = 1'b1; digit_idx = 4'd1;  end
               5'd6:    begin use_digit = 1'b1; digit_idx = 4'd2;  end
               5'd7:    lit_ch = CH_LS;
               5'd8:    begin use_digit = 1'b1; digit_idx = 4'd5;  end
               5'd9:    begin use_digit = 1'b1; digit_idx = 4'd6;  end
               5'd10:   lit_ch = item.sign2_neg ? CH_MINUS : CH_PLUS;
               5'd11:   begin use_digit = 1'b1; digit_idx = 4'd11; end
               5'd12:   begin use_digit = 1'b1; digit_idx = 4'd12; end
               5'd13:   lit_ch = CH_LR;
               5'd14:   begin use_digit = 1'b1; digit_idx = 4'd8;  end
               5'd15:   begin use_digit = 1'b1; digit_idx = 4'd9;  end
               5'd16:   begin use_digit = 1'b1; digit_idx = 4'd10; end
               5'd17:   lit_ch = CH_LS;
               5'd18:   begin use_digit = 1'b1; digit_idx = 4'd13; end
               5'd19:   begin use_digit = 1'b1; digit_idx = 4'd14; end
               5'd20:   lit_ch = CH_SPACE;
               5'd21:   lit_ch = CH_UT;
               default: lit_ch = CH_ZERO;
            endcase
         end
         default: begin
            // plain floating point
            case (pos) inside
               5'd0:           lit_ch = sign_ch;
               5'd1:           use_digit = 1'b1;
               5'd2:           lit_ch = CH_DOT;
               [5'd3:5'd16]: begin
                  use_digit = 1'b1;
                  digit_idx = 4'(pos - 5'd2);
               end
               5'd17:          lit_ch = CH_UE;
               5'd18:          lit_ch = item.exp_pos ? CH_PLUS : CH_MINUS;
               5'd20:          lit_ch = CH_ZERO + {4'd0, v[7:4]};
               5'd21:          lit_ch = CH_ZERO + {4'd0, v[3:0]};
               default:        lit_ch = CH_ZERO;
            endcase
         end
      endcase
   end

   assign character = use_digit ? nib_char(item.digits[digit_idx]) : lit_ch;

endmodule

[sv/bcd_number_to_ascii_formatter.sv]
// Top level of the BCD number to ASCII formatter: item register, position counter, result register.
//
// Usage:
//   req_ channel takes one 10-byte BCD number (bytes 0..7 on req_mantissa_bytes,
//   bytes 8..9 on req_exponent_bytes). rsp_ channel returns its string one
//   character per transfer, with position, a last flag and an error flag.
//   A number is decoded as it is taken into the item register; the position
//   counter then walks it through the character mux into the result register.
//   Throughput: one character per cycle while the result register is free or
//   rsp_ready is high; a string is 22 characters long, 18 for a long
//   fraction, 5 for ERROR. The next number is taken in the cycle its last
//   character moves to the result register, so numbers follow with no gap.
//   Stall: when rsp_ready is low with a character waiting, the result
//   register holds, the counter stops, and req_ready stays low until the
//   current string's last character moves out.
//   Reset: synchronous, active high; clears both valid flags and the counter,
//   dropping any number in flight.
module bcd_number_to_ascii_formatter (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [63:0] req_mantissa_bytes,
   input  logic [15:0] req_exponent_bytes,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_character,
   output logic [4:0]  rsp_char_position,
   output logic        rsp_is_last,
   output logic        rsp_is_error
);
   import bcdf_pkg::*;

   item_type         dec_item;
   item_type         item_ff, item_in;
   logic             item_valid_ff, item_valid_in;
   logic [POS_W-1:0] pos_ff, pos_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [7:0]       char_ff, char_in;
   logic [POS_W-1:0] rpos_ff, rpos_in;
   logic             last_ff, last_in;
   logic             err_ff, err_in;
   logic [7:0]       sel_char;
   logic             sel_last;
   logic             advance;
   logic             req_xfer;

   bcdf_decode u_decode (
      .mantissa_bytes (req_mantissa_bytes),
      .exponent_bytes (req_exponent_bytes),
      .item           (dec_item)
   );

   bcdf_char_sel u_char_sel (
      .item      (item_ff),
      .pos       (pos_ff),
      .character (sel_char),
      .is_last   (sel_last)
   );

   // move one character into the result register when it is free
   assign advance   = item_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !item_valid_ff || (advance && sel_last);
   assign req_xfer  = req_valid && req_ready;

   // item register and position counter
   always_comb begin
      item_in       = item_ff;
      item_valid_in = item_valid_ff;
      pos_in        = pos_ff;
      if (advance) begin
         pos_in = pos_ff + 5'd1;
         if (sel_last) begin
            item_valid_in = 1'b0;
            pos_in        = '0;
         end
      end
      if (req_xfer) begin
         item_in       = dec_item;
         item_valid_in = 1'b1;
         pos_in        = '0;
      end
   end

   // result register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      char_in      = char_ff;
      rpos_in      = rpos_ff;
      last_in      = last_ff;
      err_in       = err_ff;
      if (advance) begin
         rsp_valid_in = 1'b1;
         char_in      = sel_char;
         rpos_in      = pos_ff;
         last_in      = sel_last;
         err_in       = item_ff.fmt == FMT_ERROR;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
         pos_ff        <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         item_valid_ff <= item_valid_in;
         pos_ff        <= pos_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // payload, no reset
   always_ff @(posedge clock) begin
      item_ff <= item_in;
      char_ff <= char_in;
      rpos_ff <= rpos_in;
      last_ff <= last_in;
      err_ff  <= err_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_character     = char_ff;
   assign rsp_char_position = rpos_ff;
   assign rsp_is_last       = last_ff;
   assign rsp_is_error      = err_ff;

endmodule

[bench/bcd_number_to_ascii_formatter_tb.sv]
// Testbench for the BCD number formatter: directed table and random numbers, checked per character.
module bcd_number_to_ascii_formatter_tb;
   import bcdf_pkg::*;

   localparam int    N_RANDOM       = 86;
   localparam int    HOLD_CYCLES    = 300;
   localparam int    WATCHDOG_LIMIT = 2000;
   localparam int    TAIL_CYCLES    = 16;
   localparam int    SIGN2_NEG_MIN  = 5;
   localparam string ERROR_TEXT     = "ERROR";
   localparam string ZERO_TEXT      = "+0.00000000000000E+000";

   // how a table row is checked: typed-in text or the predictor
   typedef enum logic [1:0] {CHK_MODEL, CHK_ERROR_TEXT, CHK_ZERO_TEXT} chk_type;

   // receiver stall patterns
   typedef enum logic [1:0] {SINK_OPEN, SINK_COIN, SINK_PERIODIC, SINK_SLOW} sink_mode_type;

   typedef struct packed {
      chk_type     chk;
      logic [63:0] mant;
      logic [15:0] expw;
   } number_type;

   typedef struct packed {
      logic [7:0] ch;
      logic [4:0] pos;
      logic       last;
      logic       err;
   } char_type;

   // directed numbers; byte 0 is the rightmost byte of mant
   localparam int N_DIRECTED = 24;
   localparam number_type DIRECTED [N_DIRECTED] = '{
      '{CHK_ERROR_TEXT, 64'h0000_0000_0000_00F0, 16'h0000},
      '{CHK_ERROR_TEXT, 64'hFFFF_FFFF_FFFF_FFFF, 16'hFFFF},
      '{CHK_ERROR_TEXT, 64'h9999_9999_9999_99F9, 16'h0123},
      '{CHK_ZERO_TEXT,  64'h0000_0000_0000_0000, 16'h0000},
      '{CHK_ZERO_TEXT,  64'h1234_5678_9012_3425, 16'h0000},
      '{CHK_ZERO_TEXT,  64'hFFFF_FFFF_FFFF_FF8F, 16'h0000},
      '{CHK_MODEL,      64'h0000_0000_0000_0001, 16'h0100},
      '{CHK_MODEL,      64'h9999_9999_9999_9909, 16'h0599},
      '{CHK_MODEL,      64'h1234_5678_9012_3405, 16'h0500},
      '{CHK_MODEL,      64'h5555_5555_5555_5505, 16'hFFFF},
      '{CHK_MODEL,      64'h0000_0000_0000_0000, 16'h04FF},
      '{CHK_MODEL,      64'h8765_4321_0987_6503, 16'h0001},
      '{CHK_MODEL,      64'hFEDC_BAFE_DCBA_AB0A, 16'h0142},
      '{CHK_MODEL,      64'h1234_5678_9012_3421, 16'h0103},
      '{CHK_MODEL,      64'h1234_5678_9012_3421, 16'h0117},
      '{CHK_MODEL,      64'h1234_5678_9012_3421, 16'h0118},
      '{CHK_MODEL,      64'h9876_5432_1098_7624, 16'h0600},
      '{CHK_MODEL,      64'h9876_5432_1098_7624, 16'h0050},
      '{CHK_MODEL,      64'hFFFF_FFFF_FFFF_FF2F, 16'hFFFF},
      '{CHK_MODEL,      64'h1234_5678_9012_3483, 16'h0104},
      '{CHK_MODEL,      64'h1234_5678_9012_3483, 16'h0105},
      '{CHK_MODEL,      64'hABCD_EF98_7654_3280, 16'h0A05},
      '{CHK_MODEL,      64'h0000_0000_0000_0070, 16'h0123},
      '{CHK_MODEL,      64'h9999_9999_9999_99E9, 16'h1999}
   };

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [63:0] req_mantissa_bytes = '0;
   logic [15:0] req_exponent_bytes = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [7:0]  rsp_character;
   logic [4:0]  rsp_char_position;
   logic        rsp_is_last;
   logic        rsp_is_error;

   number_type plan [$];
   char_type   pending_chars [$];
   int         n_errors = 0;
   logic       hold_go = 1'b0;

   bcd_number_to_ascii_formatter dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_mantissa_bytes (req_mantissa_bytes),
      .req_exponent_bytes (req_exponent_bytes),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_character      (rsp_character),
      .rsp_char_position  (rsp_char_position),
      .rsp_is_last        (rsp_is_last),
      .rsp_is_error       (rsp_is_error)
   );

   initial begin : clock_gen
      forever #5 clock = ~clock;
   end

   task automatic report(input string what);
      $display("MISMATCH @%0t: %s", $time, what);
      n_errors++;
   endtask

   function automatic logic [7:0] digit_char(input logic [3:0] n);
      return (n == 4'd10) ? CH_LA : CH_ZERO + {4'd0, n};
   endfunction

   function automatic void push_char(input logic [7:0] ch, input int pos, input bit last,
                                     input bit err);
      char_type c;
      c.ch   = ch;
      c.pos  = pos[4:0];
      c.last = last;
      c.err  = err;
      pending_chars.push_back(c);
   endfunction

   function automatic void expect_text(input string t, input bit err);
      for (int i = 0; i < t.len(); i++)
         push_char(t[i], i, i == t.len() - 1, err);
   endfunction

   // builds the character string of one number and queues it
   function automatic void predict_chars(input logic [63:0] mant, input logic [15:0] expw);
      logic [7:0]  s [22];
      logic [3:0]  dig [15];
      logic [3:0]  kind;
      logic [15:0] e;
      logic [7:0]  sgn;
      int          val, mag, v, len;
      bit          pos, err;
      len  = 22;
      err  = 1'b0;
      kind = mant[7:4];
      e    = expw;
      sgn  = CH_PLUS;
      foreach (s[i]) s[i] = CH_ZERO;
      if (e >= NEG_BIAS) begin
         sgn = CH_MINUS;
         e   = e - NEG_BIAS;
      end
      // digit 0 is the low nibble of byte 0, then high before low for bytes 1..7
      dig[0] = mant[3:0];
      for (int k = 1; k < 8; k++) begin
         dig[2*k-1] = mant[8*k+4 +: 4];
         dig[2*k]   = mant[8*k +: 4];
      end
      val = 100 * e[11:8] + 10 * e[7:4] + e[3:0];
      pos = val >= EXP_ZERO;
      mag = pos ? val - EXP_ZERO : EXP_ZERO - val;

      if (kind == KIND_ERROR) begin
         s[0] = CH_UE; s[1] = CH_UR; s[2] = CH_UR; s[3] = CH_UO; s[4] = CH_UR;
         len = 5;
         err = 1'b1;
      end else if (expw == 16'h0000) begin
         s[0] = CH_PLUS; s[2] = CH_DOT; s[17] = CH_UE; s[18] = CH_PLUS;
      end else if (kind == KIND_FRAC) begin
         // fraction: no point, blanks past the magnitude, B marker kept
         s[0] = sgn;
         for (int i = 0; i < 15; i++) s[i+1] = digit_char(dig[i]);
         s[16] = CH_UE;
         for (int i = 1; i < 22; i++)
            if (i > mag) s[i] = CH_SPACE;
         s[17] = CH_UB;
         len = (mag <= 17) ? 22 : 18;
      end else if (kind == KIND_RADICAL) begin
         // radical: fixed shuffle of the digits
         s[0]  = sgn;
         s[1]  = digit_char(dig[3]);  s[2]  = digit_char(dig[4]);  s[3]  = CH_LR;
         s[4]  = digit_char(dig[0]);  s[5]  = digit_char(dig[1]);  s[6]  = digit_char(dig[2]);
         s[7]  = CH_LS;
         s[8]  = digit_char(dig[5]);  s[9]  = digit_char(dig[6]);
         s[10] = (e[7:0] >= SIGN2_NEG_MIN) ? CH_MINUS : CH_PLUS;
         s[11] = digit_char(dig[11]); s[12] = digit_char(dig[12]); s[13] = CH_LR;
         s[14] = digit_char(dig[8]);  s[15] = digit_char(dig[9]);  s[16] = digit_char(dig[10]);
         s[17] = CH_LS;
         s[18] = digit_char(dig[13]); s[19] = digit_char(dig[14]);
         s[20] = CH_SPACE;            s[21] = CH_UT;
      end else begin
         // plain float with three exponent characters
         s[0] = sgn;
         s[1] = digit_char(dig[0]);
         s[2] = CH_DOT;
         for (int i = 1; i < 15; i++) s[2+i] = digit_char(dig[i]);
         s[17] = CH_UE;
         s[18] = pos ? CH_PLUS : CH_MINUS;
         v = (mag % 10) + (mag / 100) + (((mag % 100) / 10) << 4);
         s[19] = CH_ZERO + {4'd0, v[11:8]};
         s[20] = CH_ZERO + {4'd0, v[7:4]};
         s[21] = CH_ZERO + {4'd0, v[3:0]};
      end
      for (int i = 0; i < len; i++) push_char(s[i], i, i == len - 1, err);
   endfunction

   // mostly BCD digits and well-formed exponents, some raw noise
   function automatic number_type random_number();
      number_type r;
      logic [3:0] hi, tens, ones;
      int         pick, bcd2;
      r.chk = CHK_MODEL;
      for (int k = 0; k < 16; k++)
         r.mant[4*k +: 4] = ($urandom_range(0, 9) != 0) ? 4'($urandom_range(0, 9))
                                                        : 4'($urandom_range(10, 15));
      pick = $urandom_range(0, 99);
      if (pick < 8)       r.mant[7:4] = KIND_ERROR;
      else if (pick < 38) r.mant[7:4] = KIND_FRAC;
      else if (pick < 68) r.mant[7:4] = KIND_RADICAL;
      else                r.mant[7:4] = 4'($urandom_range(0, 15));
      pick = $urandom_range(0, 99);
      if (pick < 8) begin
         r.expw = '0;
      end else if (pick < 70) begin
         hi = 4'($urandom_range(0, 1));
         if ($urandom_range(0, 1) != 0) hi = hi + 4'd5;
         bcd2 = ($urandom_range(0, 1) != 0) ? $urandom_range(0, 25) : $urandom_range(0, 99);
         tens = 4'(bcd2 / 10);
         ones = 4'(bcd2 % 10);
         r.expw = {4'd0, hi, tens, ones};
      end else begin
         r.expw = 16'($urandom());
      end
      return r;
   endfunction

   // receiver: changing stall patterns plus one long hold-off
   initial begin : result_sink
      sink_mode_type mode;
      int            span, phase, hold_left;
      bit            held;
      mode = SINK_OPEN; span = 0; phase = 0; hold_left = 0; held = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_go && !held) begin
            held      = 1'b1;
            hold_left = HOLD_CYCLES;
         end
         if (reset) begin
            rsp_ready <= 1'b0;
         end else if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            if (span == 0) begin
               mode = sink_mode_type'($urandom_range(0, 3));
               span = $urandom_range(10, 150);
            end
            span--;
            phase++;
            case (mode)
               SINK_OPEN:     rsp_ready <= 1'b1;
               SINK_COIN:     rsp_ready <= ($urandom_range(0, 1) != 0);
               SINK_PERIODIC: rsp_ready <= (phase % 4) != 3;
               default:       rsp_ready <= ($urandom_range(0, 3) == 0);
            endcase
         end
      end
   end

   // sender, checker and watchdog, one step per clock
   initial begin : stimulus_and_check
      number_type cur;
      char_type   want;
      int         idx, idle, gap, burst, tail;
      bit         done, rsp_xfer, req_xfer, drain;
      foreach (DIRECTED[i]) plan.push_back(DIRECTED[i]);
      repeat (N_RANDOM) plan.push_back(random_number());
      idx = 0; idle = 0; gap = 0; tail = 0; done = 1'b0;
      burst = $urandom_range(1, 8);
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      while (!done) begin
         @(posedge clock);
         rsp_xfer = rsp_valid && rsp_ready;
         req_xfer = req_valid && req_ready;

         // result transfer against the oldest expected character
         if (rsp_xfer) begin
            if (pending_chars.size() == 0) begin
               report($sformatf("character %h at position %0d with none expected",
                                rsp_character, rsp_char_position));
            end else begin
               want = pending_chars.pop_front();
               if (rsp_character !== want.ch)
                  report($sformatf("pos %0d: character %h, expected %h",
                                   want.pos, rsp_character, want.ch));
               if (rsp_char_position !== want.pos)
                  report($sformatf("position %0d, expected %0d", rsp_char_position, want.pos));
               if (rsp_is_last !== want.last)
                  report($sformatf("pos %0d: last flag %b, expected %b",
                                   want.pos, rsp_is_last, want.last));
               if (rsp_is_error !== want.err)
                  report($sformatf("pos %0d: error flag %b, expected %b",
                                   want.pos, rsp_is_error, want.err));
            end
         end

         // request transfer: queue the characters it should produce
         if (req_xfer) begin
            cur = plan[idx];
            case (cur.chk)
               CHK_ERROR_TEXT: expect_text(ERROR_TEXT, 1'b1);
               CHK_ZERO_TEXT:  expect_text(ZERO_TEXT, 1'b0);
               default:        predict_chars(cur.mant, cur.expw);
            endcase
            idx++;
            if (idx == N_DIRECTED + 40) hold_go <= 1'b1;
         end

         // watchdog on cycles without any transfer
         if (rsp_xfer || req_xfer) idle = 0;
         else idle++;
         if (idle >= WATCHDOG_LIMIT) begin
            report($sformatf("no transfer for %0d cycles, %0d characters outstanding",
                             idle, pending_chars.size()));
            done = 1'b1;
         end

         // sender bursts; pause until drained after the table and once more later
         drain = (idx == N_DIRECTED || idx == N_DIRECTED + 80) && pending_chars.size() != 0;
         if (!req_valid || req_ready) begin
            if (idx < plan.size() && gap == 0 && !drain) begin
               req_valid          <= 1'b1;
               req_mantissa_bytes <= plan[idx].mant;
               req_exponent_bytes <= plan[idx].expw;
               if (burst > 1) begin
                  burst--;
               end else begin
                  burst = $urandom_range(1, 12);
                  gap   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 30);
               end
            end else begin
               req_valid <= 1'b0;
               if (gap > 0) gap--;
            end
         end

         // all sent and drained: keep watching for stray output, then stop
         if (idx == plan.size() && pending_chars.size() == 0) begin
            tail++;
            if (tail >= TAIL_CYCLES) done = 1'b1;
         end
      end

      if (n_errors == 0)
         $display("** bcd_number_to_ascii_formatter: PASSED **");
      else
         $display("** bcd_number_to_ascii_formatter: FAILED **");
      $finish;
   end

endmodule
